[rtl/point_plane_residual_stats_unit_defines.svh]
// Assertion macros used by the top-level RTL
`ifndef POINT_PLANE_RESIDUAL_STATS_UNIT_DEFINES_SVH
`define POINT_PLANE_RESIDUAL_STATS_UNIT_DEFINES_SVH

// implication checked every clock, off during reset
`define PPRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PPRS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pprs_pkg.sv]
package pprs_pkg;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_POINT  = 2'd1;
    localparam logic [1:0] OP_REPORT = 2'd2;

    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_POINT  = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;

    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_PLANES    = 1'b1;

    localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

    // controller -> datapath
    typedef struct packed {
        logic       capture;     // latch input word
        logic       load_write;  // write plane table
        logic       dist_start;  // reset best to threshold for a new point
        logic       dist_step;   // evaluate plane at plane_idx
        logic       point_commit;
        logic       div_start;   // start mean division
        logic       sqrt_start;
        logic       row_load;    // build report row plane_idx
        logic       clear_acc;
        logic [5:0] plane_idx;
    } pprs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_busy;
        logic sqrt_busy;
        logic dist_busy;
    } pprs_stat_t;

endpackage

[rtl/pprs_ctrl.sv]
module pprs_ctrl #(
    parameter int MAX_PLANES = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  logic [1:0]         in_op,
    input  logic [3:0]         planes_in_use,
    input  logic               out_busy,
    input  pprs_pkg::pprs_stat_t stat,
    output logic               idle,
    output logic               out_load,
    output logic               out_last,
    output pprs_pkg::pprs_cmd_t cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIST  = 3'd1;
    localparam logic [2:0] S_DWAIT = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_SQRT  = 3'd4;
    localparam logic [2:0] S_ROWS  = 3'd5;
    localparam logic [2:0] S_PEMIT = 3'd6;

    // op_reg marker once the rms quotient has been started
    localparam logic [1:0] OP_RMS_PHASE = 2'd3;

    logic [2:0] state_reg, state_next;
    logic [5:0] idx_reg, idx_next;
    logic [1:0] op_reg, op_next;
    logic [6:0] n_act, rows;
    logic [6:0] mp;

    assign mp = 7'(MAX_PLANES);
    assign n_act = ({3'd0, planes_in_use} > mp) ? mp : {3'd0, planes_in_use};
    assign rows = (n_act == 7'd0) ? 7'd1 : ((n_act > 7'd8) ? 7'd8 : n_act);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.plane_idx = idx_reg;
        out_load   = 1'b0;
        out_last   = 1'b1;
        idle       = (state_reg == S_IDLE) && !out_busy;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.capture = 1'b1;
                    op_next = in_op;
                    idx_next = '0;
                    case (in_op)
                        pprs_pkg::OP_LOAD:   state_next = S_PEMIT;
                        pprs_pkg::OP_POINT:
                        begin
                            cmd.dist_start = 1'b1;
                            state_next = S_DIST;
                        end
                        pprs_pkg::OP_REPORT: state_next = S_DIV;
                        default:             state_next = S_IDLE;
                    endcase
                end
            end
            S_DIST:
            begin
                if ({1'b0, idx_reg} < n_act)
                begin
                    cmd.dist_step = 1'b1;
                    idx_next = idx_reg + 6'd1;
                end
                else
                    state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (!stat.dist_busy)
                begin
                    cmd.point_commit = 1'b1;
                    state_next = S_PEMIT;
                end
            end
            S_PEMIT:
            begin
                if (!out_busy)
                begin
                    if (op_reg == pprs_pkg::OP_LOAD)
                        cmd.load_write = 1'b1;
                    out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (!stat.div_busy && !stat.sqrt_busy)
                begin
                    cmd.sqrt_start = (op_reg != OP_RMS_PHASE);
                    op_next = OP_RMS_PHASE;
                    if (op_reg == OP_RMS_PHASE)
                        state_next = S_ROWS;
                end
            end
            S_ROWS:
            begin
                out_last = ({1'b0, idx_reg} + 7'd1 == rows);
                if (!out_busy)
                begin
                    cmd.row_load = 1'b1;
                    out_load = 1'b1;
                    idx_next = idx_reg + 6'd1;
                    if (out_last)
                    begin
                        cmd.clear_acc = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            op_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            op_reg    <= op_next;
        end
    end
endmodule

[rtl/pprs_div.sv]
// restoring divider, 64 / 32, one quotient bit per cycle
module pprs_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [63:0] quotient
);
    logic [6:0]  cnt_reg;
    logic [63:0] q_reg;
    logic [32:0] rem_reg;
    logic [31:0] d_reg;
    logic [32:0] shifted;

    assign busy = (cnt_reg != 7'd0);
    assign quotient = q_reg;
    assign shifted = {rem_reg[31:0], q_reg[63]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (start)
            cnt_reg <= 7'd64;
        else if (busy)
            cnt_reg <= cnt_reg - 7'd1;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end
        else if (busy)
        begin
            if (shifted >= {1'b0, d_reg})
            begin
                rem_reg <= shifted - {1'b0, d_reg};
                q_reg   <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                q_reg   <= {q_reg[62:0], 1'b0};
            end
        end
    end
endmodule

[rtl/pprs_sqrt.sv]
// digit-by-digit integer square root, one result bit per cycle
module pprs_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        busy,
    output logic [31:0] root
);
    logic [5:0]  cnt_reg;
    logic [63:0] v_reg;
    logic [33:0] rem_reg;
    logic [31:0] r_reg;
    logic [33:0] trial;
    logic [33:0] rem_sh;

    assign busy = (cnt_reg != 6'd0);
    assign root = r_reg;
    assign rem_sh = {rem_reg[31:0], v_reg[63:62]};
    assign trial = {r_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (start)
            cnt_reg <= 6'd32;
        else if (busy)
            cnt_reg <= cnt_reg - 6'd1;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= radicand;
            rem_reg <= '0;
            r_reg   <= '0;
        end
        else if (busy)
        begin
            v_reg <= {v_reg[61:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg <= rem_sh - trial;
                r_reg   <= {r_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                r_reg   <= {r_reg[30:0], 1'b0};
            end
        end
    end
endmodule

[rtl/pprs_datapath.sv]
module pprs_datapath #(
    parameter int MAX_PLANES    = 8,
    parameter int FRACTION_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pprs_pkg::pprs_cmd_t cmd,
    output pprs_pkg::pprs_stat_t stat,
    input  logic [1:0]          in_op,
    input  logic [2:0]          in_slot,
    input  logic [31:0]         in_x,
    input  logic [31:0]         in_y,
    input  logic [31:0]         in_z,
    input  logic [31:0]         in_d,
    input  logic [30:0]         threshold,
    input  logic [3:0]          planes_in_use,
    input  logic                out_last,
    output logic [1:0]          r_kind,
    output logic [2:0]          r_plane,
    output logic                r_assigned,
    output logic [30:0]         r_residual,
    output logic [31:0]         r_count,
    output logic [31:0]         r_seen,
    output logic [31:0]         r_nassigned,
    output logic [30:0]         r_mean,
    output logic [30:0]         r_rms,
    output logic [30:0]         r_max,
    output logic                r_last
);
    localparam int IW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

    logic [31:0] nx_mem [MAX_PLANES];
    logic [31:0] ny_mem [MAX_PLANES];
    logic [31:0] nz_mem [MAX_PLANES];
    logic [31:0] off_mem [MAX_PLANES];
    logic [31:0] cnt_reg [MAX_PLANES];

    logic [1:0]  op_reg;
    logic [2:0]  slot_reg;
    logic [31:0] px_reg, py_reg, pz_reg, pd_reg;

    logic [31:0] seen_reg, nasg_reg, max_reg;
    logic [63:0] sum_reg, sq_reg;
    logic [30:0] best_reg;
    logic [5:0]  bestk_reg;
    logic        hit_reg;

    // distance pipeline: stage1 products, stage2 sum/abs
    logic        s1_v_reg, s2_v_reg;
    logic [5:0]  s1_k_reg, s2_k_reg;
    logic signed [63:0] px_p_reg, py_p_reg, pz_p_reg;
    logic signed [31:0] s1_d_reg;
    logic [30:0] s2_dist_reg;
    logic signed [63:0] ssum, sabs;
    logic [IW-1:0] ridx;
    logic [IW-1:0] widx;

    assign ridx = cmd.plane_idx[IW-1:0];
    assign widx = IW'(slot_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= in_op; slot_reg <= in_slot;
            px_reg <= in_x; py_reg <= in_y; pz_reg <= in_z; pd_reg <= in_d;
        end
    end

    // plane table, reset to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PLANES; i++)
            begin
                nx_mem[i] <= '0; ny_mem[i] <= '0; nz_mem[i] <= '0; off_mem[i] <= '0;
            end
        end
        else if (cmd.load_write && ({4'd0, slot_reg} < 7'(MAX_PLANES)))
        begin
            nx_mem[widx]  <= px_reg;
            ny_mem[widx]  <= py_reg;
            nz_mem[widx]  <= pz_reg;
            off_mem[widx] <= pd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0; s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= cmd.dist_step;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_k_reg <= cmd.plane_idx;
        px_p_reg <= $signed(nx_mem[ridx]) * $signed(px_reg);
        py_p_reg <= $signed(ny_mem[ridx]) * $signed(py_reg);
        pz_p_reg <= $signed(nz_mem[ridx]) * $signed(pz_reg);
        s1_d_reg <= $signed(off_mem[ridx]);
        s2_k_reg <= s1_k_reg;
        s2_dist_reg <= (sabs > 64'sh7FFF_FFFF) ? pprs_pkg::DIST_MAX : sabs[30:0];
    end

    assign ssum = (px_p_reg >>> FRACTION_BITS) + (py_p_reg >>> FRACTION_BITS)
                + (pz_p_reg >>> FRACTION_BITS) + 64'(s1_d_reg);
    assign sabs = ssum[63] ? -ssum : ssum;

    assign stat.dist_busy = s1_v_reg | s2_v_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.dist_start)
        begin
            best_reg <= threshold; bestk_reg <= '0; hit_reg <= 1'b0;
        end
        else if (s2_v_reg && (s2_dist_reg < best_reg))
        begin
            best_reg <= s2_dist_reg; bestk_reg <= s2_k_reg; hit_reg <= 1'b1;
        end
    end

    // accumulators
    logic [63:0] sq_best, sum_n, sq_n;
    assign sq_best = {33'd0, best_reg} * {33'd0, best_reg};
    assign sum_n = sum_reg + {33'd0, best_reg};
    assign sq_n = sq_reg + sq_best;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0; nasg_reg <= '0; sum_reg <= '0; sq_reg <= '0; max_reg <= '0;
            for (int i = 0; i < MAX_PLANES; i++)
                cnt_reg[i] <= '0;
        end
        else if (cmd.clear_acc)
        begin
            seen_reg <= '0; nasg_reg <= '0; sum_reg <= '0; sq_reg <= '0; max_reg <= '0;
            for (int i = 0; i < MAX_PLANES; i++)
                cnt_reg[i] <= '0;
        end
        else if (cmd.point_commit)
        begin
            if (seen_reg != '1) seen_reg <= seen_reg + 32'd1;
            if (hit_reg)
            begin
                if (nasg_reg != '1) nasg_reg <= nasg_reg + 32'd1;
                if (cnt_reg[bestk_reg[IW-1:0]] != '1)
                    cnt_reg[bestk_reg[IW-1:0]] <= cnt_reg[bestk_reg[IW-1:0]] + 32'd1;
                sum_reg <= (sum_n < sum_reg) ? '1 : sum_n;
                sq_reg  <= (sq_n < sq_reg) ? '1 : sq_n;
                if ({1'b0, best_reg} > max_reg) max_reg <= {1'b0, best_reg};
            end
        end
    end

    // report math: mean first, then rms quotient then root
    logic        dv_busy, sq_busy, div_sel_reg, div_go;
    logic [63:0] quo, mean_q_reg;
    logic [31:0] root;
    logic [30:0] mean_reg;

    assign div_go = cmd.div_start | cmd.sqrt_start;

    always_ff @(posedge clk)
    begin
        if (cmd.div_start) div_sel_reg <= 1'b0;
        if (cmd.sqrt_start)
        begin
            div_sel_reg <= 1'b1;
            mean_q_reg <= quo;
        end
    end

    pprs_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_go),
        .dividend(cmd.sqrt_start ? sq_reg : sum_reg),
        .divisor(nasg_reg), .busy(dv_busy), .quotient(quo)
    );

    // root starts as soon as the rms quotient settles (divider busy falls)
    logic dv_busy_q_reg, sq_go;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) dv_busy_q_reg <= 1'b0;
        else        dv_busy_q_reg <= dv_busy;
    end

    assign sq_go = div_sel_reg && dv_busy_q_reg && !dv_busy;

    pprs_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_go), .radicand(quo),
        .busy(sq_busy), .root(root)
    );

    assign stat.div_busy  = dv_busy | sq_go;
    assign stat.sqrt_busy = sq_busy;

    always_comb
        mean_reg = (mean_q_reg > 64'h7FFF_FFFF) ? pprs_pkg::DIST_MAX : mean_q_reg[30:0];

    // output row formation
    logic none_in_use;
    assign none_in_use = (planes_in_use == 4'd0);

    always_ff @(posedge clk)
    begin
        if (cmd.point_commit || cmd.row_load || (cmd.load_write) ||
            (op_reg == pprs_pkg::OP_LOAD && !cmd.row_load && cmd.plane_idx == '0))
        begin
            r_kind <= pprs_pkg::KIND_LOAD; r_plane <= slot_reg; r_assigned <= 1'b0;
            r_residual <= '0; r_count <= '0; r_seen <= '0; r_nassigned <= '0;
            r_mean <= '0; r_rms <= '0; r_max <= '0; r_last <= 1'b1;
            if (cmd.point_commit)
            begin
                r_kind <= pprs_pkg::KIND_POINT;
                r_plane <= hit_reg ? bestk_reg[2:0] : 3'd0;
                r_assigned <= hit_reg;
                r_residual <= hit_reg ? best_reg : '0;
                r_seen <= (seen_reg != '1) ? seen_reg + 32'd1 : seen_reg;
                r_nassigned <= (hit_reg && nasg_reg != '1) ? nasg_reg + 32'd1 : nasg_reg;
            end
            if (cmd.row_load)
            begin
                r_kind <= pprs_pkg::KIND_REPORT;
                r_plane <= cmd.plane_idx[2:0];
                r_count <= none_in_use ? '0 : cnt_reg[ridx];
                r_seen <= seen_reg; r_nassigned <= nasg_reg;
                r_mean <= (nasg_reg == '0) ? '0 : mean_reg;
                r_rms <= (nasg_reg == '0) ? '0 :
                         (root > {1'b0, pprs_pkg::DIST_MAX} ? pprs_pkg::DIST_MAX : root[30:0]);
                r_max <= max_reg[30:0];
                r_last <= out_last;
            end
        end
    end
endmodule

[rtl/point_plane_residual_stats_unit.sv]
// Channel | Dir | Fields (low bit up)
// s_axis  | in  | tdata: plane_slot[2:0], coord_x, coord_y, coord_z, plane_offset_in;
//         |     | tuser: operation
// m_axis  | out | tdata: plane_id, point_assigned, residual, counts, mean, rms, max; tuser: kind; tlast
// cfg     | in  | cfg_index 0 threshold, 1 planes_in_use; cfg_data
// A point feeds one plane distance per cycle through a two-stage multiply/sum
// pipeline, over the planes in use. A report runs the 64-step divider twice and
// the 32-step root, then builds its rows in order, waiting while the output stalls.
// Reset clears tables and accumulators at once. The output register holds a word
// until taken; the block then waits for it before building the next.
`include "point_plane_residual_stats_unit_defines.svh"

module point_plane_residual_stats_unit #(
    parameter int MAX_PLANES    = 8,
    parameter int FRACTION_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,  // plane_slot, coord_x, coord_y, coord_z, plane_offset_in
    input  logic [1:0]   s_axis_tuser,  // operation
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [223:0] m_axis_tdata,  // plane_id, point_assigned, point_residual,
                                        // plane_point_count, points_seen, points_assigned,
                                        // mean_abs_error, rms_error, max_abs_error
    output logic [1:0]   m_axis_tuser,  // result_kind
    output logic         m_axis_tlast,  // last_row
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    logic [30:0] thr_reg;
    logic [3:0]  piu_reg;
    logic        ov_reg;
    logic        idle, out_load, out_last, in_fire;
    pprs_pkg::pprs_cmd_t  cmd;
    pprs_pkg::pprs_stat_t stat;
    logic [1:0]  r_kind;
    logic [2:0]  r_plane;
    logic        r_assigned, r_last;
    logic [30:0] r_residual, r_mean, r_rms, r_max;
    logic [31:0] r_count, r_seen, r_nassigned;

    assign cfg_ready = 1'b1;
    assign s_axis_tready = idle;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 31'd6554;
            piu_reg <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == pprs_pkg::CFG_THRESHOLD) thr_reg <= cfg_data[30:0];
            else                                     piu_reg <= cfg_data[3:0];
        end
    end

    pprs_ctrl #(.MAX_PLANES(MAX_PLANES)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_op(s_axis_tuser),
        .planes_in_use(piu_reg), .out_busy(ov_reg && !m_axis_tready), .stat(stat),
        .idle(idle), .out_load(out_load), .out_last(out_last), .cmd(cmd)
    );

    pprs_datapath #(.MAX_PLANES(MAX_PLANES), .FRACTION_BITS(FRACTION_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_op(s_axis_tuser), .in_slot(s_axis_tdata[2:0]),
        .in_x(s_axis_tdata[34:3]), .in_y(s_axis_tdata[66:35]),
        .in_z(s_axis_tdata[98:67]), .in_d(s_axis_tdata[130:99]),
        .threshold(thr_reg), .planes_in_use(piu_reg), .out_last(out_last),
        .r_kind(r_kind), .r_plane(r_plane), .r_assigned(r_assigned),
        .r_residual(r_residual), .r_count(r_count), .r_seen(r_seen),
        .r_nassigned(r_nassigned), .r_mean(r_mean), .r_rms(r_rms),
        .r_max(r_max), .r_last(r_last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (out_load)
            ov_reg <= 1'b1;
        else if (m_axis_tready)
            ov_reg <= 1'b0;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tuser  = r_kind;
    assign m_axis_tlast  = r_last;
    assign m_axis_tdata  = {r_max, r_rms, r_mean, r_nassigned, r_seen, r_count,
                            r_residual, r_assigned, r_plane};

    // held word must not move while the sink stalls
    `PPRS_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output word changed while stalled")
    // no new word accepted while a result is stuck
    `PPRS_ASSERT_IMP(a_in_gate, clk, rst_n, s_axis_tready, !m_axis_tvalid || m_axis_tready, "input ready while output stalled")
    // load and point results are single words
    `PPRS_ASSERT_IMP(a_single_last, clk, rst_n, m_axis_tvalid && (m_axis_tuser != pprs_pkg::KIND_REPORT), m_axis_tlast, "single word result without tlast")
endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

// Residual statistics scoreboard: tracks the plane table and accumulators,
// predicts result words for each accepted input word, checks them in order.
class residual_scoreboard;
    logic [31:0] nx [8];
    logic [31:0] ny [8];
    logic [31:0] nz [8];
    logic [31:0] off [8];
    logic [31:0] hits [8];
    logic [31:0] seen_cnt;
    logic [31:0] asg_cnt;
    logic [63:0] dsum;
    logic [63:0] sqsum;
    logic [30:0] dmax;
    logic [30:0] thresh;
    logic [3:0]  planes;
    // expected words: {tlast, tuser, tdata}
    logic [226:0] pending [$];
    int errors;

    function new();
        thresh = 31'd6554;
        planes = 0;
        errors = 0;
        for (int i = 0; i < 8; i++)
        begin
            nx[i] = 0; ny[i] = 0; nz[i] = 0; off[i] = 0; hits[i] = 0;
        end
        clear_acc();
    endfunction

    function void clear_acc();
        for (int i = 0; i < 8; i++)
            hits[i] = 0;
        seen_cnt = 0; asg_cnt = 0; dsum = 0; sqsum = 0; dmax = 0;
    endfunction

    function void queue_word(logic [226:0] e);
        pending = {pending, e};
    endfunction

    function void write_reg(logic idx, logic [31:0] val);
        if (idx == pprs_pkg::CFG_THRESHOLD)
            thresh = val[30:0];
        else
            planes = val[3:0];
    endfunction

    function logic [63:0] floor_prod(logic [31:0] a, logic [31:0] b);
        logic signed [63:0] p;
        p = $signed(a) * $signed(b);
        return p >>> 16;
    endfunction

    function logic [30:0] distance(int k, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        logic signed [63:0] s;
        s = floor_prod(nx[k], x) + floor_prod(ny[k], y) + floor_prod(nz[k], z)
            + {{32{off[k][31]}}, off[k]};
        if (s < 0)
            s = -s;
        return ($unsigned(s) > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : s[30:0];
    endfunction

    function logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] r;
        r = 0;
        for (int b = 31; b >= 0; b--)
            if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v)
                r = r | (64'd1 << b);
        return r;
    endfunction

    function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = a + b;
        return s[64] ? '1 : s[63:0];
    endfunction

    function void note_input(logic [1:0] op, logic [135:0] d);
        logic [2:0] slot;
        logic [31:0] x, y, z;
        logic [223:0] w;
        int n, best_k, rows;
        logic [30:0] best, dk;
        logic hit;
        logic [63:0] mean, rms;
        slot = d[2:0]; x = d[34:3]; y = d[66:35]; z = d[98:67];
        n = (planes > 8) ? 8 : planes;
        w = 0;
        if (op == pprs_pkg::OP_LOAD)
        begin
            nx[slot] = x; ny[slot] = y; nz[slot] = z; off[slot] = d[130:99];
            w[2:0] = slot;
            queue_word({1'b1, pprs_pkg::KIND_LOAD, w});
        end
        else if (op == pprs_pkg::OP_POINT)
        begin
            best = thresh; best_k = 0; hit = 0;
            for (int k = 0; k < n; k++)
            begin
                dk = distance(k, x, y, z);
                if (dk < best)
                begin
                    best = dk; best_k = k; hit = 1;
                end
            end
            if (seen_cnt != '1) seen_cnt++;
            if (hit)
            begin
                if (asg_cnt != '1) asg_cnt++;
                if (hits[best_k] != '1) hits[best_k]++;
                dsum = sat_add(dsum, best);
                sqsum = sat_add(sqsum, 64'(best) * 64'(best));
                if (best > dmax) dmax = best;
                w[2:0] = 3'(best_k); w[3] = 1; w[34:4] = best;
            end
            w[98:67] = seen_cnt; w[130:99] = asg_cnt;
            queue_word({1'b1, pprs_pkg::KIND_POINT, w});
        end
        else if (op == pprs_pkg::OP_REPORT)
        begin
            mean = 0; rms = 0;
            if (asg_cnt != 0)
            begin
                mean = dsum / asg_cnt;
                rms = isqrt(sqsum / asg_cnt);
                if (mean > 64'h7FFF_FFFF) mean = 64'h7FFF_FFFF;
                if (rms > 64'h7FFF_FFFF) rms = 64'h7FFF_FFFF;
            end
            rows = (n == 0) ? 1 : n;
            for (int r = 0; r < rows; r++)
            begin
                w = 0;
                w[2:0] = 3'(r);
                w[66:35] = (n == 0) ? 32'd0 : hits[r];
                w[98:67] = seen_cnt; w[130:99] = asg_cnt;
                w[161:131] = mean[30:0]; w[192:162] = rms[30:0]; w[223:193] = dmax;
                queue_word({(r == rows - 1), pprs_pkg::KIND_REPORT, w});
            end
            clear_acc();
        end
    endfunction

    task report(string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    task check_result(logic last, logic [1:0] kind, logic [223:0] d);
        logic [226:0] e;
        if (pending.size() == 0)
        begin
            report("unexpected result word");
            return;
        end
        e = pending.pop_front();
        if (e[225:224] !== kind) report($sformatf("kind %0d vs %0d", kind, e[225:224]));
        if (e[226] !== last) report($sformatf("tlast %0b vs %0b", last, e[226]));
        if (e[2:0] !== d[2:0]) report($sformatf("plane_id %0d vs %0d", d[2:0], e[2:0]));
        if (e[3] !== d[3]) report("point_assigned");
        if (e[34:4] !== d[34:4]) report($sformatf("residual %h vs %h", d[34:4], e[34:4]));
        if (e[66:35] !== d[66:35]) report($sformatf("plane count %0d vs %0d", d[66:35], e[66:35]));
        if (e[98:67] !== d[98:67]) report($sformatf("points_seen %0d vs %0d", d[98:67], e[98:67]));
        if (e[130:99] !== d[130:99]) report("points_assigned");
        if (e[161:131] !== d[161:131]) report($sformatf("mean %h vs %h", d[161:131], e[161:131]));
        if (e[192:162] !== d[192:162]) report($sformatf("rms %h vs %h", d[192:162], e[192:162]));
        if (e[223:193] !== d[223:193]) report($sformatf("max %h vs %h", d[223:193], e[223:193]));
    endtask
endclass

module tb;
    localparam logic [1:0] OP_SPARE = 2'd3;   // operation with no result

    logic         clk = 0;
    logic         rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = 0;   // plane_slot, coord_x, coord_y, coord_z, plane_offset_in
    logic [1:0]   s_axis_tuser = 0;   // operation
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [223:0] m_axis_tdata;       // plane_id, assigned, residual, counts, mean, rms, max
    logic [1:0]   m_axis_tuser;       // result_kind
    logic         m_axis_tlast;       // last_row
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [0:0]   cfg_index = 0;
    logic [31:0]  cfg_data = 0;

    residual_scoreboard sb;
    bit calm = 0;       // no idling on either side while set
    int stim_done = 0;

    always #1 clk = ~clk;

    point_plane_residual_stats_unit DUT (.*);

    // receiver: random stalls, checks every taken word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tlast, m_axis_tuser, m_axis_tdata);
            m_axis_tready <= calm || ($urandom_range(99) >= 22);
        end
    end

    // tvalid stays up between words unless a gap or a drain drops it
    task automatic send_word(logic [1:0] op, logic [135:0] d);
        bit gap;
        gap = !calm && ($urandom_range(99) < 22);
        if (gap)
        begin
            s_axis_tvalid <= 0;
            while (gap)
            begin
                @(posedge clk);
                gap = !calm && ($urandom_range(99) < 22);
            end
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= op;
        s_axis_tdata <= d;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_input(op, d);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        // a report that still computes, or an ignored word, settles here
        repeat (300) @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [31:0] val);
        drain();
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, val);
        cfg_valid <= 0;
    endtask

    function automatic logic [31:0] rnd32();
        return $urandom();
    endfunction

    // small coordinate, about +-4 m, so distances land near the threshold
    function automatic logic [31:0] near32();
        return $urandom_range(32'h0008_0000) - 32'h0004_0000;
    endfunction

    task automatic load_plane(logic [2:0] slot, logic [31:0] x, logic [31:0] y,
                              logic [31:0] z, logic [31:0] d);
        send_word(pprs_pkg::OP_LOAD, {5'd0, d, z, y, x, slot});
    endtask

    task automatic point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        send_word(pprs_pkg::OP_POINT, {5'd0, rnd32(), z, y, x, 3'($urandom())});
    endtask

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: no planes, report with nothing assigned
        point(32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_word(pprs_pkg::OP_REPORT, '0);
        // unknown operation gives no word
        send_word(OP_SPARE, {136{1'b1}});
        write_cfg(pprs_pkg::CFG_PLANES, 4);
        load_plane(3'd0, 32'h0001_0000, 0, 0, 0);
        load_plane(3'd1, 32'h0001_0000, 0, 0, 0);        // tie with plane 0
        load_plane(3'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        load_plane(3'd3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        point(32'h0000_0800, 0, 0);
        point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        point(32'hFFFF_FFFF, 0, 0);
        send_word(pprs_pkg::OP_REPORT, '0);
        write_cfg(pprs_pkg::CFG_THRESHOLD, 31'h7FFF_FFFF);
        write_cfg(pprs_pkg::CFG_PLANES, 15);             // clamps to eight
        point(32'h8000_0000, 32'h7FFF_FFFF, 0);
        point(0, 0, 0);
        send_word(pprs_pkg::OP_REPORT, '0);
        write_cfg(pprs_pkg::CFG_THRESHOLD, 0);           // nothing can be assigned
        point(0, 0, 0);
        send_word(pprs_pkg::OP_REPORT, '0);

        // random phases across settings
        for (int ph = 0; ph < 10; ph++)
        begin
            write_cfg(pprs_pkg::CFG_THRESHOLD, (ph % 3 == 0) ? 32'($urandom()) :
                      32'($urandom_range(32'h0004_0000)));
            write_cfg(pprs_pkg::CFG_PLANES, (ph == 9) ? 8 : $urandom_range(15));
            calm = (ph == 4);
            for (int i = 0; i < 8; i++)
                if ($urandom_range(3) != 0)
                    load_plane(3'(i), $signed(near32()) >>> 1, $signed(near32()) >>> 1,
                               $signed(near32()) >>> 1, near32());
            for (int i = 0; i < 36; i++)
            begin
                int r;
                r = $urandom_range(99);
                if (r < 75)
                    point(near32(), near32(), near32());
                else if (r < 82)
                    point(rnd32(), rnd32(), rnd32());
                else if (r < 88)
                    load_plane(3'($urandom()), rnd32(), rnd32(), rnd32(), rnd32());
                else if (r < 95)
                    send_word(pprs_pkg::OP_REPORT, {$urandom(), $urandom(), $urandom(),
                                                    $urandom(), 8'($urandom())});
                else
                    send_word(OP_SPARE, {$urandom(), $urandom(), $urandom(), $urandom(),
                                         8'($urandom())});
                if (ph == 2 && i == 10)
                    drain();                             // pause for all results
            end
            send_word(pprs_pkg::OP_REPORT, '0);
        end
        calm = 0;
        drain();
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

[point_plane_residual_stats_unit.f]
+incdir+rtl
rtl/pprs_pkg.sv
rtl/pprs_ctrl.sv
rtl/pprs_div.sv
rtl/pprs_sqrt.sv
rtl/pprs_datapath.sv
rtl/point_plane_residual_stats_unit.sv
tb/sv/tb.sv
